/* rtl/core/cnrt_pkg.sv */
package cnrt_pkg;

    localparam int NUMBER_W       = 31;
    localparam int QUOT_W         = NUMBER_W - 3;
    localparam int TOKEN_W        = 4;
    localparam int POS_W          = 4;
    localparam int MAX_TOKENS_DEF = 20;

    // token codes
    localparam logic [TOKEN_W-1:0] TOK_LING = 4'd0;
    localparam logic [TOKEN_W-1:0] TOK_ONE  = 4'd1;
    localparam logic [TOKEN_W-1:0] TOK_SHI  = 4'd10;
    localparam logic [TOKEN_W-1:0] TOK_WAN  = 4'd13;

    // pending pushes for one digit, taken group first
    localparam int PEND_GRP  = 0;
    localparam int PEND_UNIT = 1;
    localparam int PEND_DIG  = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_PUSH,
        ST_FIN,
        ST_EMIT
    } state_t;

endpackage

/* rtl/core/cnrt_in_if.sv */
interface cnrt_in_if;
    logic                          valid;
    logic                          ready;
    logic [cnrt_pkg::NUMBER_W-1:0] number_value;

    modport source (output valid, output number_value, input ready);
    modport sink   (input valid, input number_value, output ready);
endinterface

/* rtl/core/cnrt_out_if.sv */
interface cnrt_out_if;
    logic                         valid;
    logic                         ready;
    logic [cnrt_pkg::TOKEN_W-1:0] token_code;
    logic                         last_token;

    modport source (output valid, output token_code, output last_token, input ready);
    modport sink   (input valid, input token_code, input last_token, output ready);
endinterface

/* rtl/core/cnrt_ram.sv */
module cnrt_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 20,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/cnrt_div10.sv */
// Divide by ten: reciprocal multiply registered, quotient and remainder next cycle.
module cnrt_div10 (
    input  logic                          clk,
    input  logic                          load,
    input  logic [cnrt_pkg::NUMBER_W-1:0] x,
    output logic [cnrt_pkg::QUOT_W-1:0]   q,
    output logic [3:0]                    r
);

    localparam int PROD_W = cnrt_pkg::NUMBER_W + 32;
    localparam logic [31:0] RECIP = 32'hCCCC_CCCD;
    localparam int SHIFT = 35;

    logic [PROD_W-1:0] prod_reg;
    logic [3:0]        xlo_reg;
    logic [3:0]        q10_lo;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= PROD_W'(x) * PROD_W'(RECIP);
            xlo_reg  <= x[3:0];
        end
    end

    assign q      = prod_reg[SHIFT +: cnrt_pkg::QUOT_W];
    // low nibble of q*10 is enough, the remainder is below ten
    assign q10_lo = {q[0], 3'b000} + {q[2:0], 1'b0};
    assign r      = xlo_reg - q10_lo;

endmodule

/* rtl/core/chinese_number_reading_tokens_core.sv */
// Chinese number reading tokens.
//
// number_in (sink): one word carries a 31-bit unsigned number. The block is
// ready only when idle; it holds one number at a time.
// token_out (source): the syllable tokens of that number, most significant
// first, one word each; last_token is set on the final word. Zero reads as a
// single ling.
//
// Sequence: digits are peeled off the low end by one shared divide-by-ten unit,
// each digit in two steps (ST_MUL multiplies, ST_DIV takes quotient and
// remainder); each stacked token is then pushed in its own ST_PUSH step since
// the token stack has a single write port; ST_FIN sets up the read, then the
// token words leave the stack RAM one per cycle while the receiver does not
// stall. The next number is accepted no sooner than the cycle after the last
// word.
//
// Reset (rst_n low, async) returns the sequencer to idle with an empty stack.
// When the receiver stalls, the current token word is held until taken; no
// new number is accepted until the last word has gone.
module chinese_number_reading_tokens_core #(
    parameter int MAX_TOKENS = cnrt_pkg::MAX_TOKENS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    cnrt_in_if.sink           number_in,
    cnrt_out_if.source        token_out
);

    localparam int CNT_W  = $clog2(MAX_TOKENS + 1);
    localparam int ADDR_W = $clog2(MAX_TOKENS);
    localparam int TW     = cnrt_pkg::TOKEN_W;
    localparam int NW     = cnrt_pkg::NUMBER_W;
    localparam int PW     = cnrt_pkg::POS_W;

    cnrt_pkg::state_t state_reg, state_next;

    // control state
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [1:0]        done_reg, done_next;
    logic [2:0]        pend_reg, pend_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;

    // data path
    logic [NW-1:0]     rem_reg, rem_next;
    logic [3:0]        digit_reg, digit_next;
    logic [TW-1:0]     top_tok_reg, top_tok_next;   // last pushed
    logic [TW-1:0]     sec_tok_reg, sec_tok_next;   // pushed before that

    // shared divider
    logic                        div_load;
    logic [cnrt_pkg::QUOT_W-1:0] div_q;
    logic [3:0]                  div_r;

    // stack RAM
    logic              we;
    logic [TW-1:0]     wdata;
    logic [TW-1:0]     rdata;

    // scratch
    logic              grp_slot;
    logic [2:0]        pend_left;
    logic [CNT_W-1:0]  top_cnt;

    cnrt_div10 u_div10 (
        .clk  (clk),
        .load (div_load),
        .x    (rem_reg),
        .q    (div_q),
        .r    (div_r)
    );

    cnrt_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_TOKENS)
    ) u_stack (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (wdata),
        .raddr (idx_next),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cnrt_pkg::ST_IDLE;
            count_reg <= '0;
            pos_reg   <= '0;
            done_reg  <= '0;
            pend_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            done_reg  <= done_next;
            pend_reg  <= pend_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        digit_reg   <= digit_next;
        top_tok_reg <= top_tok_next;
        sec_tok_reg <= sec_tok_next;
    end

    // group slot of the current place: wan for places 4..7, yi for 8..11
    assign grp_slot = pos_reg[3];

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        done_next    = done_reg;
        pend_next    = pend_reg;
        idx_next     = idx_reg;
        rem_next     = rem_reg;
        digit_next   = digit_reg;
        top_tok_next = top_tok_reg;
        sec_tok_next = sec_tok_reg;
        div_load     = 1'b0;
        we           = 1'b0;
        wdata        = cnrt_pkg::TOK_LING;
        pend_left    = pend_reg;
        top_cnt      = count_reg;

        number_in.ready      = 1'b0;
        token_out.valid      = 1'b0;
        token_out.token_code = rdata;
        token_out.last_token = (idx_reg == '0);

        case (state_reg)
            cnrt_pkg::ST_IDLE:
            begin
                number_in.ready = 1'b1;
                if (number_in.valid)
                begin
                    count_next = '0;
                    pos_next   = '0;
                    done_next  = '0;
                    rem_next   = number_in.number_value;
                    if (number_in.number_value == '0)
                    begin
                        // zero reads as one ling
                        digit_next = '0;
                        pend_next  = 3'b000;
                        pend_next[cnrt_pkg::PEND_DIG] = 1'b1;
                        state_next = cnrt_pkg::ST_PUSH;
                    end
                    else
                    begin
                        state_next = cnrt_pkg::ST_MUL;
                    end
                end
            end

            cnrt_pkg::ST_MUL:
            begin
                div_load   = 1'b1;
                state_next = cnrt_pkg::ST_DIV;
            end

            cnrt_pkg::ST_DIV:
            begin
                rem_next   = NW'(div_q);
                digit_next = div_r;
                pend_next  = 3'b000;
                if (div_r != 4'd0)
                begin
                    if (pos_reg >= PW'(4) && pos_reg < PW'(12) && !done_reg[grp_slot])
                    begin
                        pend_next[cnrt_pkg::PEND_GRP] = 1'b1;
                        done_next[grp_slot] = 1'b1;
                    end
                    pend_next[cnrt_pkg::PEND_UNIT] = (pos_reg[1:0] != 2'd0);
                    pend_next[cnrt_pkg::PEND_DIG]  = 1'b1;
                end
                else if (count_reg != '0 && top_tok_reg != cnrt_pkg::TOK_LING)
                begin
                    // first zero of a run
                    pend_next[cnrt_pkg::PEND_DIG] = 1'b1;
                end

                if (pend_next == 3'b000)
                begin
                    pos_next   = pos_reg + PW'(1);
                    state_next = (div_q == '0) ? cnrt_pkg::ST_FIN : cnrt_pkg::ST_MUL;
                end
                else
                begin
                    state_next = cnrt_pkg::ST_PUSH;
                end
            end

            cnrt_pkg::ST_PUSH:
            begin
                if (pend_reg[cnrt_pkg::PEND_GRP])
                begin
                    wdata = TW'(cnrt_pkg::TOK_WAN + TW'(grp_slot));
                    pend_left[cnrt_pkg::PEND_GRP] = 1'b0;
                end
                else if (pend_reg[cnrt_pkg::PEND_UNIT])
                begin
                    wdata = TW'(cnrt_pkg::TOK_SHI + TW'(pos_reg[1:0]) - TW'(1));
                    pend_left[cnrt_pkg::PEND_UNIT] = 1'b0;
                end
                else
                begin
                    wdata = digit_reg;
                    pend_left[cnrt_pkg::PEND_DIG] = 1'b0;
                end

                if (count_reg < CNT_W'(MAX_TOKENS))
                begin
                    we           = 1'b1;
                    count_next   = count_reg + CNT_W'(1);
                    top_tok_next = wdata;
                    sec_tok_next = top_tok_reg;
                end

                pend_next = pend_left;
                if (pend_left == 3'b000)
                begin
                    pos_next   = pos_reg + PW'(1);
                    state_next = (rem_reg == '0) ? cnrt_pkg::ST_FIN : cnrt_pkg::ST_MUL;
                end
            end

            cnrt_pkg::ST_FIN:
            begin
                // a leading "yi shi" reads as "shi"
                if (count_reg > CNT_W'(1) && top_tok_reg == cnrt_pkg::TOK_ONE &&
                    sec_tok_reg == cnrt_pkg::TOK_SHI)
                begin
                    top_cnt = count_reg - CNT_W'(1);
                end
                idx_next   = ADDR_W'(top_cnt - CNT_W'(1));
                state_next = cnrt_pkg::ST_EMIT;
            end

            cnrt_pkg::ST_EMIT:
            begin
                token_out.valid = 1'b1;
                if (token_out.ready)
                begin
                    if (idx_reg == '0)
                    begin
                        state_next = cnrt_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - ADDR_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = cnrt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
